// File: src/vmap_pkg.sv
// Shared types, constants and address mirroring functions for the video memory access port.
// No dependencies; imported by vmap_vram and video_memory_access_port.
`timescale 1ns / 1ps
`default_nettype none

package vmap_pkg;

  localparam int unsigned AddrW     = 14;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MemDepth  = 16384;
  localparam int unsigned ClrW      = AddrW + 1;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register numbers
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // nametable mirroring modes
  typedef enum logic [1:0] {
    MIR_COPY   = 2'd0,
    MIR_PAIRED = 2'd1,
    MIR_SINGLE = 2'd2,
    MIR_FOUR   = 2'd3
  } mirror_e;

  localparam logic [AddrW-1:0] PAL_BASE    = 14'h3F00;
  localparam logic [AddrW-1:0] PAL_MIRROR  = 14'h3F10;
  localparam logic [AddrW-1:0] PAL_MASK    = 14'h3F1F;
  localparam logic [AddrW-1:0] PAL_BG_MASK = 14'h3F0F;
  localparam logic [AddrW-1:0] PAL_PAGE    = 14'h3F00;
  localparam logic [AddrW-1:0] NT_SINGLE   = 14'h23FF;
  localparam logic [AddrW-1:0] NT_HALF     = 14'h0800;
  localparam logic [AddrW-1:0] NT_QUARTER  = 14'h0400;
  localparam logic [AddrW-1:0] NT_LO       = 14'h2400;
  localparam logic [AddrW-1:0] NT_HI       = 14'h2C00;

  // one memory access request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } vmap_req_t;

  // where a data port write lands
  typedef struct packed {
    logic [AddrW-1:0] addr0;
    logic [AddrW-1:0] addr1;
    logic             dual;
    logic             pal;
  } vmap_plan_t;

  // nametable area 0x2000 to 0x2fff
  function automatic logic in_nametable(logic [AddrW-1:0] p);
    return p[13:12] == 2'b10;
  endfunction

  // address read through the buffer
  function automatic logic [AddrW-1:0] fetch_addr(logic [AddrW-1:0] p, mirror_e mode);
    logic [AddrW-1:0] a;
    a = p;
    if (mode == MIR_SINGLE && in_nametable(p)) begin
      a = p & NT_SINGLE;
    end else if (p > PAL_BASE) begin
      a = p & PAL_MASK;
    end else if (mode == MIR_PAIRED && p >= NT_LO && p < NT_HI) begin
      a = p - NT_QUARTER;
    end
    return a;
  endfunction

  // one or two addresses written by a data port write
  function automatic vmap_plan_t store_plan(logic [AddrW-1:0] p, mirror_e mode);
    vmap_plan_t r;
    r.addr0 = p;
    r.addr1 = p;
    r.dual  = 1'b0;
    r.pal   = 1'b0;
    if ((p & PAL_BG_MASK) == PAL_BASE) begin
      r.addr0 = PAL_BASE;
      r.addr1 = PAL_MIRROR;
      r.dual  = 1'b1;
      r.pal   = 1'b1;
    end else if ((p & PAL_PAGE) == PAL_PAGE) begin
      r.addr0 = p & PAL_MASK;
      r.pal   = 1'b1;
    end else if (in_nametable(p)) begin
      unique case (mode)
        MIR_FOUR: r.addr0 = p;
        MIR_SINGLE: r.addr0 = p & NT_SINGLE;
        MIR_COPY: begin
          r.addr1 = p ^ NT_HALF;
          r.dual  = 1'b1;
        end
        default: begin
          r.dual = 1'b1;
          if (p < NT_LO || p >= NT_HI) begin
            r.addr1 = p ^ NT_HALF;
          end else begin
            r.addr0 = p - NT_QUARTER;
            r.addr1 = p + NT_QUARTER;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/vmap_vram.sv
// Single-port 16 KiB video memory with registered read and a clearing pass after reset.
// Depends on vmap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmap_vram (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vmap_pkg::vmap_req_t req_i,
  output logic [vmap_pkg::DataW-1:0] rdata_o,
  output logic                    ready_o
);
  import vmap_pkg::*;

  logic [DataW-1:0] mem [MemDepth];
  logic [ClrW-1:0]  clr_q;
  logic [ClrW-1:0]  clr_d;
  logic [DataW-1:0] rdata_q;
  logic             clr_done;

  // clearing pass sweeps every entry once after reset
  assign clr_done = clr_q[ClrW-1];
  assign clr_d    = clr_done ? clr_q : clr_q + ClrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (!clr_done) begin
      mem[clr_q[AddrW-1:0]] <= '0;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;
  assign ready_o = clr_done;

endmodule

`default_nettype wire

// File: src/video_memory_access_port.sv
// Top level of the video memory access port: register decode, pointer, latch, buffer, output skid.
// Depends on vmap_pkg and vmap_vram.
`timescale 1ns / 1ps
`default_nettype none

// CPU-side port to a 16 KiB video memory through eight registers. Each input item is one
// register access and gives exactly one result item. A data register read passes through
// the fill state, where the single memory port's registered read refills the read buffer,
// and a mirrored data register write passes through a second write state (the second copy
// goes through the same port). After reset the memory is zeroed by a clearing pass, during
// which no item is accepted; the mirroring mode register can be written at any time when
// idle. Results queue in a two-entry output stage, so an item is taken while one result waits.
module video_memory_access_port (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: mirroring mode
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,      // mirror_mode
  // register access items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [7:0] write_data
  input  wire logic [3:0]  s_axis_tuser,    // [0] op, [3:1] reg_index
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata     // [7:0] read_data, [8] palette_written, rest 0
);
  import vmap_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;

  localparam int unsigned ResW = DataW + 1;

  logic [1:0]       state_q, state_d;
  mirror_e          mode_q;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [15:0]      latch_q, latch_d;
  logic             toggle_q, toggle_d;
  logic [DataW-1:0] buf_q, buf_d;
  logic [DataW-1:0] ctrl_q, ctrl_d;
  logic [AddrW-1:0] addr2_q, addr2_d;
  logic [DataW-1:0] wdata_q, wdata_d;

  logic             out_valid_q, out_valid_d;
  logic [ResW-1:0]  out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  logic [ResW-1:0]  skid_data_q, skid_data_d;

  logic             op;
  logic [2:0]       reg_index;
  logic [DataW-1:0] wr_data;
  logic             accept;
  logic             take;
  logic             mem_ready;
  logic [DataW-1:0] mem_rdata;
  vmap_req_t        req;
  vmap_plan_t       plan;
  logic [AddrW-1:0] ptr_step;
  logic [DataW-1:0] rd;
  logic             pal;

  assign op        = s_axis_tuser[0];
  assign reg_index = s_axis_tuser[3:1];
  assign wr_data   = s_axis_tdata;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && mem_ready && !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid_q && m_axis_tready;

  // pointer advance after a data port access
  assign ptr_step = ptr_q + (ctrl_q[2] ? AddrW'(32) : AddrW'(1));
  assign plan     = store_plan(ptr_q, mode_q);

  // register decode and memory request
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    latch_d  = latch_q;
    toggle_d = toggle_q;
    buf_d    = buf_q;
    ctrl_d   = ctrl_q;
    addr2_d  = addr2_q;
    wdata_d  = wdata_q;
    rd       = '0;
    pal      = 1'b0;
    req.we    = 1'b0;
    req.addr  = fetch_addr(ptr_q, mode_q);
    req.wdata = wr_data;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_READ) begin
            if (reg_index == REG_STATUS) begin
              toggle_d = 1'b0;
            end else if (reg_index == REG_DATA) begin
              rd      = buf_q;
              ptr_d   = ptr_step;
              state_d = ST_FILL;
            end
          end else begin
            case (reg_index)
              REG_CTRL: ctrl_d = wr_data;
              REG_SCROLL: begin
                toggle_d = ~toggle_q;
                if (toggle_q) begin
                  latch_d = {2'b00, latch_q[13:10], wr_data, 2'b00};
                end
              end
              REG_ADDR: begin
                toggle_d = ~toggle_q;
                if (!toggle_q) begin
                  latch_d = {wr_data, latch_q[7:0]};
                  ctrl_d  = {ctrl_q[7:2], wr_data[3:2]};
                end else begin
                  latch_d = {latch_q[15:8], wr_data};
                end
                ptr_d = latch_d[AddrW-1:0];
              end
              REG_DATA: begin
                req.we   = 1'b1;
                req.addr = plan.addr0;
                pal      = plan.pal;
                addr2_d  = plan.addr1;
                wdata_d  = wr_data;
                ptr_d    = ptr_step;
                if (plan.dual) begin
                  state_d = ST_WR2;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_FILL: begin
        buf_d   = mem_rdata;
        state_d = ST_IDLE;
      end
      ST_WR2: begin
        req.we    = 1'b1;
        req.addr  = addr2_q;
        req.wdata = wdata_q;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // two-entry output stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (take) begin
      out_valid_d  = skid_valid_q;
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end
    if (accept) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_data_d  = {pal, rd};
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = {pal, rd};
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MIR_COPY;
      ptr_q        <= '0;
      latch_q      <= '0;
      toggle_q     <= 1'b0;
      buf_q        <= '0;
      ctrl_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      latch_q      <= latch_d;
      toggle_q     <= toggle_d;
      buf_q        <= buf_d;
      ctrl_q       <= ctrl_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (cfg_valid_i) begin
        mode_q <= mirror_e'(cfg_data_i);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr2_q     <= addr2_d;
    wdata_q     <= wdata_d;
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  vmap_vram u_vram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (mem_rdata),
    .ready_o (mem_ready)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - ResW)'(0), out_data_q};

endmodule

`default_nettype wire

// File: tb/sv/video_memory_access_port_tb.sv
// Self-checking testbench for video_memory_access_port: register accesses in, result items out.
// Keeps its own image of the video memory, pointer, latch and buffer to predict every result.
// Depends on vmap_pkg and the video_memory_access_port RTL.
`timescale 1ns / 1ps

module video_memory_access_port_tb;
  import vmap_pkg::*;

  // registers with no behavior of their own
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;

  localparam int unsigned RunItems  = 250;
  localparam int unsigned HoldAt    = 900;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned SettleCyc = 20;

  typedef struct packed {
    logic       op;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       palette_written;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_data = '0;
  logic        cfg_ready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  video_memory_access_port u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),      // [7:0] write_data
    .s_axis_tuser  (s_tuser),      // [0] op, [3:1] reg_index
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)       // [7:0] read_data, [8] palette_written, rest 0
  );

  always #5 clk_i = ~clk_i;

  // predicted state of the block
  logic [7:0]  vram_img [MemDepth];
  logic [13:0] vram_ptr;
  logic [15:0] addr_latch;
  logic        wr_toggle;
  logic [7:0]  rd_buffer;
  logic [7:0]  ctrl_byte;
  mirror_e     mirror_mode;

  access_t     cpu_accesses[$];
  reply_t      pending_replies[$];
  int unsigned queued = 0;
  int unsigned items_taken = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // short pauses mostly, a few long ones, none at all in quiet stretches
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[12:11] == 2'b00) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // one register access applied to the predicted state
  function automatic reply_t access_register(access_t a);
    reply_t      r;
    logic [13:0] p;
    logic [7:0]  d;
    r = '0;
    p = vram_ptr;
    d = a.write_data;
    if (a.op == OP_READ) begin
      if (a.reg_index == REG_STATUS) begin
        wr_toggle = 1'b0;
      end else if (a.reg_index == REG_DATA) begin
        r.read_data = rd_buffer;
        // refill the buffer from the mirrored address
        if (mirror_mode == MIR_SINGLE && p[13:12] == 2'b10) begin
          rd_buffer = vram_img[p & 14'h23FF];
        end else if (p > 14'h3F00) begin
          rd_buffer = vram_img[p & 14'h3F1F];
        end else if (mirror_mode == MIR_PAIRED && p >= 14'h2400 && p < 14'h2C00) begin
          rd_buffer = vram_img[p - 14'h0400];
        end else begin
          rd_buffer = vram_img[p];
        end
        vram_ptr = p + (ctrl_byte[2] ? 14'd32 : 14'd1);
      end
    end else begin
      case (a.reg_index)
        REG_CTRL: begin
          ctrl_byte = d;
        end
        REG_SCROLL: begin
          wr_toggle = ~wr_toggle;
          if (!wr_toggle) addr_latch = {2'b00, addr_latch[13:10], d, 2'b00};
        end
        REG_ADDR: begin
          wr_toggle = ~wr_toggle;
          if (wr_toggle) begin
            addr_latch[15:8] = d;
            ctrl_byte[1:0] = addr_latch[11:10];
          end else begin
            addr_latch[7:0] = d;
          end
          vram_ptr = addr_latch[13:0];
        end
        REG_DATA: begin
          if ((p & 14'h3F0F) == 14'h3F00) begin
            // background color is shared by both palette halves
            vram_img[14'h3F00] = d;
            vram_img[14'h3F10] = d;
            r.palette_written = 1'b1;
          end else if (p[13:8] == 6'h3F) begin
            vram_img[p & 14'h3F1F] = d;
            r.palette_written = 1'b1;
          end else if (p[13:12] == 2'b10) begin
            case (mirror_mode)
              MIR_FOUR: vram_img[p] = d;
              MIR_SINGLE: vram_img[p & 14'h23FF] = d;
              MIR_COPY: begin
                vram_img[p] = d;
                vram_img[p ^ 14'h0800] = d;
              end
              default: begin
                if (p < 14'h2400 || p >= 14'h2C00) begin
                  vram_img[p] = d;
                  vram_img[p ^ 14'h0800] = d;
                end else begin
                  vram_img[p - 14'h0400] = d;
                  vram_img[p + 14'h0400] = d;
                end
              end
            endcase
          end else begin
            vram_img[p] = d;
          end
          vram_ptr = p + (ctrl_byte[2] ? 14'd32 : 14'd1);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // sender: offers queued items, predicts each accepted one
  access_t     offered;
  int unsigned send_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_replies.push_back(access_register(offered));
        items_taken <= items_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (cpu_accesses.size() != 0) begin
          offered = cpu_accesses.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= offered.write_data;
          s_tuser <= {offered.reg_index, offered.op};
          send_gap = pick_pause();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, to back the block up
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  wire         holding = (hold_left != 0);

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HoldAt) begin
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end
  end

  // receiver: checks each result against the oldest prediction
  int unsigned stall_left = 0;
  reply_t      want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          $error("result item with none expected, tdata %0h", m_tdata);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (m_tdata[7:0] !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[8] !== want.palette_written) begin
            $error("palette_written: expected %0h, got %0h", want.palette_written, m_tdata[8]);
            errors++;
          end
          if (m_tdata[15:9] !== 7'd0) begin
            $error("tdata padding: expected 0, got %0h", m_tdata[15:9]);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        stall_left = pick_pause();
        m_tready <= !holding;
      end
    end
  end

  task automatic add_access(logic op, logic [2:0] idx, logic [7:0] data);
    access_t a;
    a.op = op;
    a.reg_index = idx;
    a.write_data = data;
    cpu_accesses.push_back(a);
    queued++;
  endtask

  task automatic set_pointer(logic [7:0] hi, logic [7:0] lo);
    add_access(OP_WRITE, REG_ADDR, hi);
    add_access(OP_WRITE, REG_ADDR, lo);
  endtask

  // optional status, control and scroll accesses, then pointer setup and a burst of data register traffic
  task automatic queue_run();
    logic [7:0]  hi;
    logic [7:0]  lo;
    int unsigned len;
    case ($urandom_range(0, 4))
      0: hi = 8'($urandom_range(8'h20, 8'h2F));
      1: hi = 8'h3F;
      2: hi = 8'($urandom_range(8'h00, 8'h1F));
      3: hi = 8'($urandom_range(8'h30, 8'h3E));
      default: hi = 8'($urandom_range(0, 255));
    endcase
    lo = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    len = $urandom_range(1, 8);
    if ($urandom_range(0, 1)) add_access(OP_READ, REG_STATUS, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) add_access(OP_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      add_access(OP_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
      add_access(OP_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
    end
    set_pointer(hi, lo);
    case ($urandom_range(0, 2))
      0: begin
        // write a run, then read it back through the buffer
        repeat (len) add_access(OP_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
        set_pointer(hi, lo);
        repeat (len + 1) add_access(OP_READ, REG_DATA, 8'($urandom_range(0, 255)));
      end
      1: begin
        repeat (len) begin
          add_access(1'($urandom_range(0, 1)), REG_DATA, 8'($urandom_range(0, 255)));
        end
      end
      default: begin
        repeat (len) add_access(OP_READ, REG_DATA, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic write_mirror_mode(logic [1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    mirror_mode = mirror_e'(v);
    cfg_valid <= 1'b0;
  endtask

  // waits until every item is sent and every result is back, and lets a pending second copy land
  task automatic wait_idle();
    @(negedge clk_i);
    while (cpu_accesses.size() != 0 || s_tvalid || pending_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    logic [1:0]  modes[7];
    int unsigned start;
    for (int i = 0; i < MemDepth; i++) vram_img[i] = 8'h00;
    vram_ptr = '0;
    addr_latch = '0;
    wr_toggle = 1'b0;
    rd_buffer = '0;
    ctrl_byte = '0;
    mirror_mode = MIR_COPY;
    modes[0] = MIR_COPY;
    modes[1] = MIR_FOUR;
    modes[2] = MIR_SINGLE;
    modes[3] = MIR_PAIRED;
    modes[4] = 2'($urandom_range(0, 3));
    modes[5] = 2'($urandom_range(0, 3));
    modes[6] = MIR_FOUR;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: palette corners, pointer wrap, toggle, quiet registers
    write_mirror_mode(MIR_PAIRED);
    add_access(OP_WRITE, REG_CTRL, 8'hFF);
    add_access(OP_READ, REG_STATUS, 8'h00);
    set_pointer(8'hFF, 8'hFF);
    add_access(OP_WRITE, REG_DATA, 8'h81);
    add_access(OP_WRITE, REG_CTRL, 8'h00);
    set_pointer(8'h3F, 8'h10);
    add_access(OP_WRITE, REG_DATA, 8'h5A);
    add_access(OP_READ, REG_DATA, 8'hFF);
    add_access(OP_READ, REG_DATA, 8'h00);
    add_access(OP_WRITE, REG_SCROLL, 8'hFF);
    add_access(OP_WRITE, REG_SCROLL, 8'h00);
    set_pointer(8'h24, 8'h00);
    add_access(OP_WRITE, REG_DATA, 8'hC3);
    set_pointer(8'h24, 8'h00);
    add_access(OP_READ, REG_DATA, 8'h00);
    add_access(OP_READ, REG_DATA, 8'h00);
    add_access(OP_WRITE, REG_MASK, 8'hFF);
    add_access(OP_READ, REG_CTRL, 8'h00);
    add_access(OP_READ, REG_MASK, 8'h00);
    add_access(OP_READ, REG_SPR_ADDR, 8'h00);
    add_access(OP_WRITE, REG_SPR_DATA, 8'hA5);
    add_access(OP_READ, REG_ADDR, 8'h00);
    add_access(OP_READ, REG_SCROLL, 8'h00);
    wait_idle();

    // random phases, one mirroring mode each
    foreach (modes[k]) begin
      write_mirror_mode(modes[k]);
      start = queued;
      while (queued - start < RunItems) begin
        if ($urandom_range(0, 4) == 0) begin
          add_access(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)));
        end else begin
          queue_run();
        end
      end
      wait_idle();
    end

    repeat (SettleCyc) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
